// ----- rtl/rsd_pkg.sv -----
package rsd_pkg;

    localparam int SYM_W      = 8;
    localparam int PAIR_W     = 12;
    localparam int SUM_W      = 20;
    localparam int SQ_W       = 32;
    localparam int DIST_W     = 12;
    localparam int LEN_W      = 13;
    localparam int OUT_DATA_W = 104;

    localparam logic [PAIR_W-1:0] MAX12 = '1;
    localparam logic [SUM_W-1:0]  MAX20 = '1;
    localparam logic [SQ_W-1:0]   MAX32 = '1;
    localparam logic [LEN_W-1:0]  MAX13 = '1;

    // Per-symbol outcome of the table lookup, handed to the statistics stage.
    typedef struct packed {
        logic              hit;
        logic              done;
        logic              multi;
        logic [DIST_W-1:0] dist_clip;
        logic [SUM_W-1:0]  dist_full;
        logic [SQ_W-1:0]   dist_sq;
        logic [LEN_W-1:0]  seg_len;
    } rsd_hit_t;

endpackage

// ----- rtl/symbol_recurrence_distance_stats.sv -----
// The final item passes the lookup and hit registers before m_tvalid is registered.
// Throughput: one item per cycle unless m_tready stalls a segment end, set by the
// single read-modify-write of the last-position memory per item, forwarding between
// back-to-back items. Reset (aresetn low, synchronous) empties the pipeline, the
// seen flags and the running statistics; the position memory itself is not cleared.
module symbol_recurrence_distance_stats
    import rsd_pkg::*;
#(
    parameter int MAX_SEGMENT = 4096,
    parameter int SYMBOL_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SYM_W-1:0]      s_tdata,   // [7:0] symbol
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [11:0] pair_count, [31:12] distance_sum, [63:32] distance_square_sum,
    // [75:64] distance_max, [87:76] distance_min, [100:88] segment_length
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic     s2_valid;
    rsd_hit_t s2_item;
    logic     take;

    rsd_lookup #(
        .MAX_SEGMENT(MAX_SEGMENT),
        .SYMBOL_BITS(SYMBOL_BITS)
    ) u_lookup (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .take    (take),
        .s2_valid(s2_valid),
        .s2_item (s2_item)
    );

    rsd_accum u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s2_valid(s2_valid),
        .s2_item (s2_item),
        .take    (take),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

endmodule

// ----- rtl/rsd_lookup.sv -----
module rsd_lookup
    import rsd_pkg::*;
#(
    parameter int MAX_SEGMENT = 4096,
    parameter int SYMBOL_BITS = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [SYM_W-1:0] s_tdata,
    input  logic             s_tlast,
    input  logic             take,
    output logic             s2_valid,
    output rsd_hit_t         s2_item
);

    localparam int TABLE = 1 << SYMBOL_BITS;
    localparam int PW    = $clog2(MAX_SEGMENT);
    localparam logic [PW-1:0] POS_LAST = PW'(MAX_SEGMENT - 1);

    logic [PW-1:0]          pos_mem [TABLE];

    logic                   s1_valid_reg;
    logic [SYMBOL_BITS-1:0] s1_sym_reg;
    logic                   s1_last_reg;
    logic [PW-1:0]          rd_pos_reg;
    logic                   fwd_reg;
    logic [PW-1:0]          fwd_pos_reg;
    logic [PW-1:0]          pos_reg;
    logic [TABLE-1:0]       seen_reg;
    logic [1:0]             distinct_reg;
    logic [1:0]             distinct_next;
    logic                   s2_valid_reg;
    rsd_hit_t               s2_item_reg;
    rsd_hit_t               hit_next;

    logic [15:0]            sym_wide;
    logic [SYMBOL_BITS-1:0] sym_in;
    logic                   accept;
    logic                   s1_adv;
    logic                   seen;
    logic                   done;
    logic [PW-1:0]          prev_pos;
    logic [PW-1:0]          rec_dist;
    logic [31:0]            dist32;
    logic [2*PW-1:0]        sq_full;
    logic [PW:0]            len_wide;

    assign sym_wide = 16'(s_tdata);
    assign sym_in   = sym_wide[SYMBOL_BITS-1:0];

    assign s1_adv   = s1_valid_reg && (!s2_valid_reg || take);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        seen     = seen_reg[s1_sym_reg];
        // The item ahead wrote this entry in the cycle this one was read.
        prev_pos = fwd_reg ? fwd_pos_reg : rd_pos_reg;
        rec_dist = pos_reg - prev_pos;
        dist32   = 32'(rec_dist);
        sq_full  = (2*PW)'(rec_dist) * (2*PW)'(rec_dist);
        len_wide = {1'b0, pos_reg} + (PW+1)'(1);
        done     = s1_last_reg || (pos_reg == POS_LAST);
        if (seen) begin
            distinct_next = distinct_reg;
        end else if (distinct_reg == 2'd2) begin
            distinct_next = distinct_reg;
        end else begin
            distinct_next = distinct_reg + 2'd1;
        end
        hit_next.hit       = seen;
        hit_next.done      = done;
        hit_next.multi     = (distinct_next == 2'd2);
        hit_next.dist_clip = (dist32 > 32'(MAX12)) ? MAX12 : dist32[DIST_W-1:0];
        hit_next.dist_full = SUM_W'(rec_dist);
        hit_next.dist_sq   = SQ_W'(sq_full);
        hit_next.seg_len   = (32'(len_wide) > 32'(MAX13)) ? MAX13 : LEN_W'(len_wide);
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            pos_mem[s1_sym_reg] <= pos_reg;
        end
        if (accept) begin
            rd_pos_reg <= pos_mem[sym_in];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_sym_reg  <= sym_in;
            s1_last_reg <= s_tlast;
            fwd_reg     <= s1_adv && (s1_sym_reg == sym_in);
            fwd_pos_reg <= pos_reg;
        end
        if (s1_adv) begin
            s2_item_reg <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            pos_reg      <= '0;
            seen_reg     <= '0;
            distinct_reg <= '0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                s2_valid_reg <= 1'b1;
            end else if (take) begin
                s2_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                if (done) begin
                    pos_reg      <= '0;
                    seen_reg     <= '0;
                    distinct_reg <= '0;
                end else begin
                    pos_reg              <= pos_reg + PW'(1);
                    seen_reg[s1_sym_reg] <= 1'b1;
                    distinct_reg         <= distinct_next;
                end
            end
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2_item  = s2_item_reg;

    // A repeat always lies strictly earlier in the segment.
    a_repeat_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && seen |-> pos_reg != prev_pos)
        else $error("repeat with zero distance");

    a_segment_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_adv && done |=> pos_reg == '0 && seen_reg == '0 && distinct_reg == 2'd0)
        else $error("segment state not cleared");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg && !take |=> s2_valid_reg)
        else $error("stalled item dropped");

endmodule

// ----- rtl/rsd_accum.sv -----
module rsd_accum
    import rsd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s2_valid,
    input  rsd_hit_t              s2_item,
    output logic                  take,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int PAD_W = OUT_DATA_W - (PAIR_W + SUM_W + SQ_W + 2*DIST_W + LEN_W);

    logic [PAIR_W-1:0]     pair_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [SQ_W-1:0]       sq_reg;
    logic [DIST_W-1:0]     max_reg;
    logic [DIST_W-1:0]     min_reg;
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    logic [PAIR_W-1:0]     pair_next;
    logic [SUM_W-1:0]      sum_next;
    logic [SQ_W-1:0]       sq_next;
    logic [DIST_W-1:0]     max_next;
    logic [DIST_W-1:0]     min_next;
    logic [DIST_W-1:0]     min_out;
    logic [SUM_W:0]        sum_wide;
    logic [SQ_W:0]         sq_wide;
    logic                  out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign take     = s2_valid && (!s2_item.done || out_free);

    always_comb begin
        sum_wide  = {1'b0, sum_reg} + {1'b0, s2_item.dist_full};
        sq_wide   = {1'b0, sq_reg} + {1'b0, s2_item.dist_sq};
        pair_next = pair_reg;
        sum_next  = sum_reg;
        sq_next   = sq_reg;
        max_next  = max_reg;
        min_next  = min_reg;
        if (s2_item.hit) begin
            pair_next = (pair_reg == MAX12) ? MAX12 : pair_reg + PAIR_W'(1);
            sum_next  = sum_wide[SUM_W] ? MAX20 : sum_wide[SUM_W-1:0];
            sq_next   = sq_wide[SQ_W] ? MAX32 : sq_wide[SQ_W-1:0];
            if (s2_item.dist_clip > max_reg) begin
                max_next = s2_item.dist_clip;
            end
            if (s2_item.dist_clip < min_reg) begin
                min_next = s2_item.dist_clip;
            end
        end
        // With two or more distinct symbols in the segment, the reported minimum is forced to zero.
        min_out = s2_item.multi ? '0 : min_next;
    end

    always_ff @(posedge aclk) begin
        if (take && s2_item.done) begin
            m_data_reg <= {PAD_W'(0), s2_item.seg_len, min_out, max_next,
                           sq_next, sum_next, pair_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pair_reg    <= '0;
            sum_reg     <= '0;
            sq_reg      <= '0;
            max_reg     <= '0;
            min_reg     <= MAX12;
        end else begin
            if (take && s2_item.done) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (take) begin
                if (s2_item.done) begin
                    pair_reg <= '0;
                    sum_reg  <= '0;
                    sq_reg   <= '0;
                    max_reg  <= '0;
                    min_reg  <= MAX12;
                end else begin
                    pair_reg <= pair_next;
                    sum_reg  <= sum_next;
                    sq_reg   <= sq_next;
                    max_reg  <= max_next;
                    min_reg  <= min_next;
                end
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Totals only move when a pair is scored.
    a_no_pair_no_stats: assert property (@(posedge aclk) disable iff (!aresetn)
        pair_reg == '0 |-> sum_reg == '0 && sq_reg == '0 && max_reg == '0
                           && min_reg == MAX12)
        else $error("statistics without a scored pair");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        take && s2_item.done |=> pair_reg == '0 && m_valid_reg)
        else $error("segment end not handled");

endmodule
